FILE: hdl/mau_pkg.sv
// Package for the modular arithmetic unit: payload types, command codes, helpers.
`default_nettype none
package mau_pkg;

    localparam int CmdW = 4;
    localparam int ResW = 31;
    localparam int ExpW = 63;
    localparam int RawW = 64;
    localparam int ExponentBitsDefault = 64;

    localparam logic [ResW-1:0] ModReset = 31'd998244353;

    localparam logic [CmdW-1:0] CMD_ADD    = 4'd0;
    localparam logic [CmdW-1:0] CMD_SUB    = 4'd1;
    localparam logic [CmdW-1:0] CMD_MUL    = 4'd2;
    localparam logic [CmdW-1:0] CMD_DIV    = 4'd3;
    localparam logic [CmdW-1:0] CMD_INV    = 4'd4;
    localparam logic [CmdW-1:0] CMD_POW    = 4'd5;
    localparam logic [CmdW-1:0] CMD_NEG    = 4'd6;
    localparam logic [CmdW-1:0] CMD_REDUCE = 4'd7;
    localparam logic [CmdW-1:0] CMD_CMP    = 4'd8;

    typedef struct packed {
        logic [CmdW-1:0]        command;
        logic [ResW-1:0]        operand_a;
        logic [ResW-1:0]        operand_b;
        logic [ExpW-1:0]        exponent;
        logic signed [RawW-1:0] raw_value;
    } t_in;

    typedef struct packed {
        logic [ResW-1:0] result;
        logic            equal;
    } t_out;

    // Conditional subtract: bring a value below 2*m back under m.
    function automatic logic [ResW-1:0] csub(input logic [ResW:0] x, input logic [ResW-1:0] m);
        logic [ResW:0] d;
        d = x - {1'b0, m};
        return (x >= {1'b0, m}) ? d[ResW-1:0] : x[ResW-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hdl/modular_arithmetic_unit.sv
// Modular arithmetic unit: sequencer around a shared bit-serial remainder/multiply datapath.
// Sequence: both operands are reduced first; add/sub/neg/cmp then finish directly, mul
//   runs the serial multiply, inverse runs extended Euclid steps (divide adds a multiply),
//   power does up to two modular multiplies per exponent bit, reduce a raw remainder pass.
// Throughput: one item at a time; the next transfer is taken once the result is
//   parked in the output register. The serial compare-subtract loop sets the pace.
// Reset: synchronous active-low; clears sequencer and output valid, modulus = 998244353.
`default_nettype none
module modular_arithmetic_unit #(
    parameter int EXPONENT_BITS = mau_pkg::ExponentBitsDefault
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  mau_pkg::t_in               i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output mau_pkg::t_out              o_data,
    input  logic                       i_cfg_we,
    input  logic [mau_pkg::ResW-1:0]   i_cfg_wdata
);
    import mau_pkg::*;

    // Only the low EXPONENT_BITS bits of the exponent, capped at ExpW, take part in power.
    localparam int ExpUsed = (EXPONENT_BITS < ExpW) ? EXPONENT_BITS : ExpW;
    localparam logic [ExpW-1:0] ExpMask = {ExpW{1'b1}} >> (ExpW - ExpUsed);

    // Sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_REM    = 4'd1;   // serial remainder, one bit per cycle
    localparam logic [3:0] S_RA     = 4'd2;
    localparam logic [3:0] S_RB     = 4'd3;   // dispatch on command
    localparam logic [3:0] S_MUL    = 4'd4;   // serial modular multiply
    localparam logic [3:0] S_EUDIV  = 4'd5;   // one Euclid quotient, one bit per cycle
    localparam logic [3:0] S_EUNEXT = 4'd6;
    localparam logic [3:0] S_INVFIX = 4'd7;
    localparam logic [3:0] S_POW    = 4'd8;
    localparam logic [3:0] S_POWA   = 4'd9;
    localparam logic [3:0] S_POWB   = 4'd10;
    localparam logic [3:0] S_RAWFIX = 4'd11;
    localparam logic [3:0] S_MULRES = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0]       r_state, r_ret;
    logic [ResW-1:0]  r_mod;
    logic             r_ovalid;
    t_out             r_out;

    logic [CmdW-1:0]  r_cmd;
    logic [ResW-1:0]  r_a, r_b, r_res;
    logic             r_eq;
    logic [ExpW-1:0]  r_exp;
    logic [RawW-1:0]  r_raw;
    logic [6:0]       r_cnt;

    // remainder unit
    logic [RawW-1:0]  r_src;
    logic [ResW-1:0]  r_rem;
    // multiplier
    logic [ResW-1:0]  r_x, r_y, r_acc;
    // power
    logic [ResW-1:0]  r_pa, r_pb;
    // extended Euclid
    logic [ResW-1:0]         r_ea, r_eb;
    logic signed [ResW+1:0]  r_eu, r_ev;
    logic [2*ResW-1:0]       r_erem, r_bs;
    logic signed [RawW-1:0]  r_vs, r_nu;

    logic [ResW-1:0]  w_m;
    logic [ResW-1:0]  w_rem_n, w_dbl, w_add, w_mul_n, w_inv;
    logic             w_fit;
    logic [2*ResW-1:0]      w_erem_n;
    logic signed [RawW-1:0] w_nu_n;
    logic signed [ResW+1:0] w_uneg;
    logic [RawW-1:0]  w_mag;
    logic [ResW:0]    w_sum, w_diff;

    // A zero modulus acts as one.
    assign w_m = (r_mod == '0) ? {{(ResW-1){1'b0}}, 1'b1} : r_mod;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_comb begin
        // remainder step: shift in the next bit, subtract the modulus if it fits
        w_rem_n = csub({r_rem, r_src[RawW-1]}, w_m);
        // multiply step, MSB first: double, then add x when the y bit is set
        w_dbl   = csub({r_acc, 1'b0}, w_m);
        w_add   = csub({1'b0, w_dbl} + {1'b0, r_x}, w_m);
        w_mul_n = r_y[ResW-1] ? w_add : w_dbl;
        // Euclid quotient bit: subtract the shifted divisor and shifted coefficient
        w_fit    = (r_bs <= r_erem);
        w_erem_n = w_fit ? (r_erem - r_bs) : r_erem;
        w_nu_n   = w_fit ? (r_nu - r_vs) : r_nu;
        // bring the Bezout coefficient into range; its magnitude never exceeds m
        w_uneg = r_eu + $signed({2'b00, w_m});
        w_inv  = r_eu[ResW+1] ? w_uneg[ResW-1:0] : csub({1'b0, r_eu[ResW-1:0]}, w_m);
        w_mag  = r_raw[RawW-1] ? (~r_raw + 64'd1) : r_raw;
        w_sum  = {1'b0, r_a} + {1'b0, r_rem};
        w_diff = {1'b0, r_a} + ({1'b0, w_m} - {1'b0, r_rem});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_mod    <= ModReset;
        end else begin
            if (i_cfg_we) begin
                r_mod <= i_cfg_wdata;
            end
            // drop valid on the result transfer unless a new result is parked now
            if (r_ovalid && i_ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_data.command;
                        r_b   <= i_data.operand_b;
                        r_exp <= i_data.exponent;
                        r_raw <= i_data.raw_value;
                        r_eq  <= 1'b0;
                        r_res <= '0;
                        r_src <= {i_data.operand_a, {(RawW-ResW){1'b0}}};
                        r_rem <= '0;
                        r_cnt <= 7'(ResW);
                        r_ret <= S_RA;
                        r_state <= S_REM;
                    end
                end
                S_REM: begin
                    r_rem <= w_rem_n;
                    r_src <= {r_src[RawW-2:0], 1'b0};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= r_ret;
                    end
                end
                S_RA: begin
                    r_a   <= r_rem;
                    r_src <= {r_b, {(RawW-ResW){1'b0}}};
                    r_rem <= '0;
                    r_cnt <= 7'(ResW);
                    r_ret <= S_RB;
                    r_state <= S_REM;
                end
                S_RB: begin
                    // r_rem holds reduced operand_b here
                    unique case (r_cmd)
                        CMD_ADD: begin
                            r_res <= csub(w_sum, w_m);
                            r_state <= S_DONE;
                        end
                        CMD_SUB: begin
                            r_res <= csub(w_diff, w_m);
                            r_state <= S_DONE;
                        end
                        CMD_MUL: begin
                            r_x <= r_a;
                            r_y <= r_rem;
                            r_acc <= '0;
                            r_cnt <= 7'(ResW);
                            r_ret <= S_MULRES;
                            r_state <= S_MUL;
                        end
                        CMD_DIV, CMD_INV: begin
                            r_ea <= (r_cmd == CMD_DIV) ? r_rem : r_a;
                            r_eb <= w_m;
                            r_eu <= 33'sd1;
                            r_ev <= 33'sd0;
                            r_state <= S_EUNEXT;
                        end
                        CMD_POW: begin
                            r_pa  <= (w_m == {{(ResW-1){1'b0}}, 1'b1}) ? '0
                                     : {{(ResW-1){1'b0}}, 1'b1};
                            r_pb  <= r_a;
                            r_exp <= r_exp & ExpMask;
                            r_state <= S_POW;
                        end
                        CMD_NEG: begin
                            r_res <= (r_a == '0) ? '0 : (w_m - r_a);
                            r_state <= S_DONE;
                        end
                        CMD_REDUCE: begin
                            r_src <= w_mag;
                            r_rem <= '0;
                            r_cnt <= 7'(RawW);
                            r_ret <= S_RAWFIX;
                            r_state <= S_REM;
                        end
                        CMD_CMP: begin
                            r_eq <= (r_a == r_rem);
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_res <= '0;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_MUL: begin
                    r_acc <= w_mul_n;
                    r_y   <= {r_y[ResW-2:0], 1'b0};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= r_ret;
                    end
                end
                S_MULRES: begin
                    r_res <= r_acc;
                    r_state <= S_DONE;
                end
                S_EUNEXT: begin
                    if (r_eb != '0) begin
                        r_erem <= {{ResW{1'b0}}, r_ea};
                        r_bs   <= {1'b0, r_eb, {(ResW-1){1'b0}}};
                        r_vs   <= {{(RawW-ResW-2){r_ev[ResW+1]}}, r_ev} <<< (ResW-1);
                        r_nu   <= {{(RawW-ResW-2){r_eu[ResW+1]}}, r_eu};
                        r_cnt  <= 7'(ResW);
                        r_state <= S_EUDIV;
                    end else begin
                        r_state <= S_INVFIX;
                    end
                end
                S_EUDIV: begin
                    r_erem <= w_erem_n;
                    r_nu   <= w_nu_n;
                    r_bs   <= r_bs >> 1;
                    r_vs   <= r_vs >>> 1;
                    r_cnt  <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_ea <= r_eb;
                        r_eb <= w_erem_n[ResW-1:0];
                        r_eu <= r_ev;
                        r_ev <= w_nu_n[ResW+1:0];
                        r_state <= S_EUNEXT;
                    end
                end
                S_INVFIX: begin
                    if (r_cmd == CMD_DIV) begin
                        r_x <= r_a;
                        r_y <= w_inv;
                        r_acc <= '0;
                        r_cnt <= 7'(ResW);
                        r_ret <= S_MULRES;
                        r_state <= S_MUL;
                    end else begin
                        r_res <= w_inv;
                        r_state <= S_DONE;
                    end
                end
                S_POW: begin
                    r_acc <= '0;
                    r_cnt <= 7'(ResW);
                    if (r_exp == '0) begin
                        r_res <= r_pa;
                        r_state <= S_DONE;
                    end else if (r_exp[0]) begin
                        r_x <= r_pa;
                        r_y <= r_pb;
                        r_ret <= S_POWA;
                        r_state <= S_MUL;
                    end else begin
                        r_x <= r_pb;
                        r_y <= r_pb;
                        r_ret <= S_POWB;
                        r_state <= S_MUL;
                    end
                end
                S_POWA: begin
                    r_pa  <= r_acc;
                    r_x   <= r_pb;
                    r_y   <= r_pb;
                    r_acc <= '0;
                    r_cnt <= 7'(ResW);
                    r_ret <= S_POWB;
                    r_state <= S_MUL;
                end
                S_POWB: begin
                    r_pb  <= r_acc;
                    r_exp <= r_exp >> 1;
                    r_state <= S_POW;
                end
                S_RAWFIX: begin
                    // negative input: fold the magnitude's residue back over m
                    r_res <= (r_raw[RawW-1] && r_rem != '0) ? (w_m - r_rem) : r_rem;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_ready) begin
                        r_out.result <= r_res;
                        r_out.equal  <= r_eq;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
